@@ hw/rtl/gpbd_pkg.sv @@
`timescale 1ns / 1ps

package gpbd_pkg;

  localparam int COORD_W      = 24;
  localparam int ROW_W        = 12;
  localparam int COL_W        = 10;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_W        = 52;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ    = 2'd2;

  localparam int              RESET_WIDTH  = 640;
  localparam int              RESET_HEIGHT = 480;
  localparam logic [CFG_W-1:0] RESET_RADIUS = 52'd4096;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;
    logic                      point_valid;
  } gpbd_in_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] column_index;
    logic             boundary_flag;
    logic             last_in_run;
  } gpbd_out_t;

endpackage

@@ hw/rtl/grid_point_boundary_detect.sv @@
// Boundary detection on an organized point cloud streamed in raster order.
// Input channel (in_valid/in_ready/in_data): one point per transaction, row
// by row. Output channel (out_valid/out_ready/out_data): one verdict per
// transaction. A point's verdict leaves when the point below it arrives; on
// the last row when the point to its right arrives, and the last point of the
// frame with its own arrival. One input transaction causes 0 to 3 results.
// Each result passes stages a to d and the output register before it shows.
// Throughput: one point per cycle while each point causes at most one result
// and out_ready is high; on the last row the single output register drains
// the 2 or 3 results of a point at one per cycle and the input waits for it.
// A held result does not block input while the points behind it cause none;
// a point that causes results waits in the last stage until the output
// register is free, freezing the pipeline. Configuration (cfg_we, cfg_index,
// cfg_wdata) must be written while idle (not enforced); a frame width or
// height write restarts the frame at row 0, column 0. Reset empties the
// pipeline and the output register, zeroes the counters and loads 640 x 480
// with radius squared 4096. The line store needs no clearing pass after reset.
`timescale 1ns / 1ps

module grid_point_boundary_detect import gpbd_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gpbd_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gpbd_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int CMP_W   = (SUM_W > CFG_W) ? SUM_W : CFG_W;
  localparam int MEM_W   = 3 * COORD_W + 1;
  localparam int RST_W   = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int RST_H   = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

  typedef struct packed {
    logic [RW-1:0] row;
    logic [CW-1:0] col;
    logic          has_up;
    logic          has_left;
    logic          last_row;
    logic          last_col;
    logic          vp;
    logic          vl;
    logic          vu;
  } ctl_t;

  function automatic logic [COORD_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                  logic signed [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    begin
      if (a >= b) begin
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      end else begin
        d = {b[COORD_W-1], b} - {a[COORD_W-1], a};
      end
      abs_diff = d[COORD_W-1:0];
    end
  endfunction

  // configuration
  logic [CW-1:0]    wm1_r;
  logic [RW-1:0]    hm1_r;
  logic [CFG_W-1:0] rad_r;
  logic [31:0]      cfg_w32;
  logic [31:0]      cfg_h32;
  logic [CW-1:0]    cfg_wm1;
  logic [RW-1:0]    cfg_hm1;
  logic             geom_wr;

  // raster position
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          last_col;
  logic          last_row;
  logic          acc;
  logic          adv;
  gpbd_in_t      last_pt_r;

  // line stores
  logic [MEM_W-1:0] coord_mem [MAX_WIDTH];
  logic             pend_mem  [MAX_WIDTH];
  logic [MEM_W-1:0] coord_rd_r;
  logic             pend_rd_r;
  logic             pend_we;
  logic             pend_wd;

  // pipeline
  logic a_vld_r, b_vld_r, c_vld_r, d_vld_r;
  ctl_t a_ctl_r, b_ctl_r, c_ctl_r, d_ctl_r;
  ctl_t a_ctl_fix;
  gpbd_in_t a_pt_r;
  gpbd_in_t a_lp_r;
  logic signed [COORD_W-1:0] mem_x, mem_y, mem_z;
  logic [COORD_W-1:0] b_ud_r [3];
  logic [COORD_W-1:0] b_ld_r [3];
  logic [SQ_W-1:0]    c_usq_r [3];
  logic [SQ_W-1:0]    c_lsq_r [3];
  logic [SUM_W-1:0]   d_usum_r;
  logic [SUM_W-1:0]   d_lsum_r;

  // left neighbor waiting for its final pending flag
  logic          held_vld_r;
  logic [CW-1:0] held_col_r;
  logic          held_pend_r;

  // last stage
  logic      far_u, far_l, pend_up, fu, left_set, f_self;
  gpbd_out_t res [3];
  logic [1:0] res_n;

  // output buffer
  gpbd_out_t  rb_r [3];
  logic [1:0] rb_cnt_r;
  logic       buf_free;
  logic       ld;
  logic       take;

  assign cfg_w32 = 32'(cfg_wdata[WIDTH_REG_W-1:0]);
  assign cfg_h32 = 32'(cfg_wdata[HEIGHT_REG_W-1:0]);

  always_comb begin
    if (cfg_w32 == 32'd0) begin
      cfg_wm1 = '0;
    end else if (cfg_w32 > 32'(MAX_WIDTH)) begin
      cfg_wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      cfg_wm1 = CW'(cfg_w32 - 32'd1);
    end
    if (cfg_h32 == 32'd0) begin
      cfg_hm1 = '0;
    end else if (cfg_h32 > 32'(MAX_HEIGHT)) begin
      cfg_hm1 = RW'(MAX_HEIGHT - 1);
    end else begin
      cfg_hm1 = RW'(cfg_h32 - 32'd1);
    end
  end

  assign geom_wr  = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
  assign last_col = (col_r == wm1_r);
  assign last_row = (row_r == hm1_r);

  assign buf_free = (rb_cnt_r == 2'd0) || (rb_cnt_r == 2'd1 && out_ready);
  assign adv      = !d_vld_r || (res_n == 2'd0) || buf_free;
  assign in_ready = adv;
  assign acc      = in_valid && in_ready;
  assign ld       = adv && d_vld_r && (res_n != 2'd0);
  assign out_valid = (rb_cnt_r != 2'd0);
  assign out_data  = rb_r[0];
  assign take      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r <= CW'(RST_W - 1);
      hm1_r <= RW'(RST_H - 1);
      rad_r <= RESET_RADIUS;
      col_r <= '0;
      row_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  wm1_r <= cfg_wm1;
          REG_FRAME_HEIGHT: hm1_r <= cfg_hm1;
          REG_RADIUS_SQ:    rad_r <= cfg_wdata;
          default:          ;
        endcase
      end
      if (geom_wr) begin
        col_r <= '0;
        row_r <= '0;
      end else if (acc) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + RW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

  // read old entry and store the new point in the same cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      coord_rd_r     <= coord_mem[col_r];
      coord_mem[col_r] <= {in_data.x_coord, in_data.y_coord, in_data.z_coord,
                           in_data.point_valid};
    end
  end

  // pending flags: forward a same-cycle write to the read
  assign pend_we = adv && d_vld_r && held_vld_r;
  assign pend_wd = held_pend_r || left_set;

  always_ff @(posedge clk) begin
    if (adv) begin
      pend_rd_r <= (pend_we && held_col_r == c_ctl_r.col) ? pend_wd : pend_mem[c_ctl_r.col];
    end
    if (pend_we) begin
      pend_mem[held_col_r] <= pend_wd;
    end
  end

  assign mem_x = coord_rd_r[MEM_W-1 -: COORD_W];
  assign mem_y = coord_rd_r[MEM_W-1-COORD_W -: COORD_W];
  assign mem_z = coord_rd_r[COORD_W:1];

  always_comb begin
    a_ctl_fix    = a_ctl_r;
    a_ctl_fix.vu = coord_rd_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= acc;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_pt_r           <= in_data;
      a_lp_r           <= last_pt_r;
      last_pt_r        <= in_data;
      a_ctl_r.row      <= row_r;
      a_ctl_r.col      <= col_r;
      a_ctl_r.has_up   <= (row_r != '0);
      a_ctl_r.has_left <= (col_r != '0);
      a_ctl_r.last_row <= last_row;
      a_ctl_r.last_col <= last_col;
      a_ctl_r.vp       <= in_data.point_valid;
      a_ctl_r.vl       <= last_pt_r.point_valid;
      a_ctl_r.vu       <= 1'b0;
    end
    if (adv) begin
      b_ctl_r   <= a_ctl_fix;
      b_ud_r[0] <= abs_diff(mem_x, a_pt_r.x_coord);
      b_ud_r[1] <= abs_diff(mem_y, a_pt_r.y_coord);
      b_ud_r[2] <= abs_diff(mem_z, a_pt_r.z_coord);
      b_ld_r[0] <= abs_diff(a_lp_r.x_coord, a_pt_r.x_coord);
      b_ld_r[1] <= abs_diff(a_lp_r.y_coord, a_pt_r.y_coord);
      b_ld_r[2] <= abs_diff(a_lp_r.z_coord, a_pt_r.z_coord);
      c_ctl_r   <= b_ctl_r;
      for (int i = 0; i < 3; i++) begin
        c_usq_r[i] <= SQ_W'(b_ud_r[i]) * SQ_W'(b_ud_r[i]);
        c_lsq_r[i] <= SQ_W'(b_ld_r[i]) * SQ_W'(b_ld_r[i]);
      end
      d_ctl_r  <= c_ctl_r;
      d_usum_r <= SUM_W'(c_usq_r[0]) + SUM_W'(c_usq_r[1]) + SUM_W'(c_usq_r[2]);
      d_lsum_r <= SUM_W'(c_lsq_r[0]) + SUM_W'(c_lsq_r[1]) + SUM_W'(c_lsq_r[2]);
    end
  end

  always_comb begin
    far_u    = d_ctl_r.vu && d_ctl_r.vp && (CMP_W'(d_usum_r) > CMP_W'(rad_r));
    far_l    = d_ctl_r.vl && d_ctl_r.vp && (CMP_W'(d_lsum_r) > CMP_W'(rad_r));
    pend_up  = (held_vld_r && held_col_r == d_ctl_r.col) ? held_pend_r : pend_rd_r;
    fu       = d_ctl_r.vu && (pend_up || !d_ctl_r.vp || far_u);
    left_set = d_ctl_r.has_left && d_ctl_r.vl && (!d_ctl_r.vp || far_l);
    f_self   = d_ctl_r.vp && (!d_ctl_r.has_up || !d_ctl_r.has_left || d_ctl_r.last_col ||
                              d_ctl_r.last_row || !d_ctl_r.vu || far_u ||
                              !d_ctl_r.vl || far_l);
  end

  always_comb begin
    res   = '{default: '0};
    res_n = 2'd0;
    if (d_ctl_r.has_up) begin
      res[res_n] = '{row_index: ROW_W'(d_ctl_r.row - RW'(1)),
                     column_index: COL_W'(d_ctl_r.col),
                     boundary_flag: fu, last_in_run: 1'b0};
      res_n = res_n + 2'd1;
    end
    if (d_ctl_r.has_left && d_ctl_r.last_row) begin
      res[res_n] = '{row_index: ROW_W'(d_ctl_r.row),
                     column_index: COL_W'(d_ctl_r.col - CW'(1)),
                     boundary_flag: pend_wd, last_in_run: 1'b0};
      res_n = res_n + 2'd1;
    end
    if (d_ctl_r.last_row && d_ctl_r.last_col) begin
      res[res_n] = '{row_index: ROW_W'(d_ctl_r.row),
                     column_index: COL_W'(d_ctl_r.col),
                     boundary_flag: f_self, last_in_run: 1'b0};
      res_n = res_n + 2'd1;
    end
    if (res_n != 2'd0) begin
      res[res_n - 2'd1].last_in_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vld_r <= 1'b0;
    end else if (adv && d_vld_r) begin
      held_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && d_vld_r) begin
      held_col_r  <= d_ctl_r.col;
      held_pend_r <= f_self;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_cnt_r <= 2'd0;
    end else if (ld) begin
      rb_cnt_r <= res_n;
    end else if (take) begin
      rb_cnt_r <= rb_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      rb_r <= res;
    end else if (take) begin
      rb_r[0] <= rb_r[1];
      rb_r[1] <= rb_r[2];
    end
  end

  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  assert property (@(posedge clk) disable iff (!rst_n) col_r <= wm1_r)
    else $error("column counter beyond frame width");

  assert property (@(posedge clk) disable iff (!rst_n)
      ld |-> (rb_cnt_r == 2'd0 || (rb_cnt_r == 2'd1 && out_ready)))
    else $error("result bundle overwrites pending results");

  assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && rb_cnt_r == 2'd1) |-> out_data.last_in_run)
    else $error("final result of a run lacks last_in_run");

  assert property (@(posedge clk) disable iff (!rst_n)
      (d_vld_r && d_ctl_r.has_up && held_vld_r && held_col_r == d_ctl_r.col)
      |-> (wm1_r == '0))
    else $error("held neighbor forwarded outside single-column frame");

endmodule
